// ===== hw/rtl/wcej_pkg.sv =====
// Shared types and constants for the wide code to EUC-JP converter.
package wcej_pkg;

  // Most bytes one code word can produce, terminator included
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW = 3;
  localparam int unsigned QueueDepthDefault = 2;

  // Class select and byte constants
  localparam logic [7:0] SingleShift2 = 8'h8E;
  localparam logic [7:0] SingleShift3 = 8'h8F;
  localparam logic [7:0] RowLo1 = 8'hA1;
  localparam logic [7:0] RowHi1 = 8'hA8;
  localparam logic [7:0] RowLo2 = 8'hB0;
  localparam logic [7:0] RowHi2 = 8'hF4;
  localparam logic [15:0] CircledLo = 16'hADA1;
  localparam logic [15:0] CircledHi = 16'hADB4;
  localparam logic [7:0] CircledBase = 8'hA0;
  localparam logic [7:0] AsciiOpen = 8'h28;
  localparam logic [7:0] AsciiClose = 8'h29;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] Terminator = 8'h00;

  // Code class, from bits 15 and 7 of the code word
  typedef enum logic [1:0] {
    ClassAscii    = 2'b00,
    ClassKana     = 2'b01,
    ClassExternal = 2'b10,
    ClassFull     = 2'b11
  } code_class_e;

  // One classified item: its byte list, how many bytes, and whether
  // the first slot is the invalid-code marker
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          nbytes;
    logic                     marker;
  } entry_t;

endpackage

// ===== hw/rtl/wcej_if.sv =====
// Valid/ready channel interfaces for code words in and EUC-JP bytes out.
interface wcej_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic        last_word;

  modport source (output valid, output code_word, output last_word, input ready);
  modport sink (input valid, input code_word, input last_word, output ready);
endinterface

interface wcej_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       invalid_code;
  logic       end_of_run;

  modport source (
    output valid, output out_byte, output byte_valid, output invalid_code,
    output end_of_run, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input invalid_code,
    input end_of_run, output ready
  );
endinterface

// ===== hw/rtl/wcej_front.sv =====
// Front end: classifies one code word into its list of output bytes.
module wcej_front (
  input  logic [15:0]     code_word_i,
  input  logic            last_word_i,
  output wcej_pkg::entry_t entry_o
);
  import wcej_pkg::*;

  logic [7:0]      hi;
  logic [7:0]      lo;
  logic            row_ok;
  logic            circled;
  logic [4:0]      num;
  logic [3:0]      tens;
  logic [4:0]      ones;
  logic [CntW-1:0] n;
  code_class_e     cls;

  assign hi = code_word_i[15:8];
  assign lo = code_word_i[7:0];
  assign cls = code_class_e'({code_word_i[15], code_word_i[7]});
  assign row_ok = ((hi >= RowLo1) && (hi <= RowHi1)) || ((hi >= RowLo2) && (hi <= RowHi2));
  assign circled = (code_word_i >= CircledLo) && (code_word_i <= CircledHi);

  // Split the counter value 1..20 into decimal digits
  always_comb begin
    num = 5'(lo - CircledBase);
    if (num >= 5'd20) begin
      tens = 4'd2;
      ones = num - 5'd20;
    end else if (num >= 5'd10) begin
      tens = 4'd1;
      ones = num - 5'd10;
    end else begin
      tens = 4'd0;
      ones = num;
    end
  end

  // Build the byte list, then append the terminator on the last word
  always_comb begin
    entry_o = '0;
    n = '0;
    unique case (cls)
      ClassAscii: begin
        entry_o.bytes[0] = {1'b0, code_word_i[6:0]};
        n = CntW'(1);
      end
      ClassKana: begin
        entry_o.bytes[0] = SingleShift2;
        entry_o.bytes[1] = {1'b1, code_word_i[6:0]};
        n = CntW'(2);
      end
      ClassExternal: begin
        entry_o.bytes[0] = SingleShift3;
        entry_o.bytes[1] = hi;
        entry_o.bytes[2] = lo | 8'h80;
        n = CntW'(3);
      end
      ClassFull: begin
        if (row_ok) begin
          entry_o.bytes[0] = hi;
          entry_o.bytes[1] = lo;
          n = CntW'(2);
        end else if (circled) begin
          entry_o.bytes[0] = AsciiOpen;
          if (tens != 4'd0) begin
            entry_o.bytes[1] = AsciiZero + {4'd0, tens};
            entry_o.bytes[2] = AsciiZero + {3'd0, ones};
            entry_o.bytes[3] = AsciiClose;
            n = CntW'(4);
          end else begin
            entry_o.bytes[1] = AsciiZero + {3'd0, ones};
            entry_o.bytes[2] = AsciiClose;
            n = CntW'(3);
          end
        end else begin
          entry_o.bytes[0] = Terminator;
          entry_o.marker = 1'b1;
          n = CntW'(1);
        end
      end
      default: begin
        n = CntW'(1);
      end
    endcase
    if (last_word_i) begin
      entry_o.bytes[n] = Terminator;
      n = n + CntW'(1);
    end
    entry_o.nbytes = n;
  end

endmodule

// ===== hw/rtl/wcej_queue.sv =====
// Short FIFO of classified entries between the front and back ends.
module wcej_queue #(
  parameter int unsigned Depth = wcej_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wcej_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output wcej_pkg::entry_t head_o,
  output logic             empty_o
);
  import wcej_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign head_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== hw/rtl/wcej_back.sv =====
// Back end: serializes the head entry into one output beat per cycle while the receiver is ready.
module wcej_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wcej_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  wcej_out_if.source       out_o
);
  import wcej_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q;
  logic            byte_valid_q;
  logic            invalid_q;
  logic            end_q;
  logic            load;
  logic            last_beat;
  logic            is_marker;

  assign load = !empty_i && (!out_valid_q || out_o.ready);
  assign last_beat = (idx_q == head_i.nbytes - CntW'(1));
  assign is_marker = head_i.marker && (idx_q == '0);
  assign pop_o = load && last_beat;

  // Step through the entry; restart at slot zero when it is done
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last_beat ? '0 : idx_q + CntW'(1);
    end
    out_valid_d = load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register holds the beat until it is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      byte_valid_q <= !is_marker;
      invalid_q <= is_marker;
      end_q <= last_beat;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.byte_valid = byte_valid_q;
  assign out_o.invalid_code = invalid_q;
  assign out_o.end_of_run = end_q;

endmodule

// ===== hw/rtl/wide_code_to_euc_jp_top.sv =====
// Top level of the wide code to EUC-JP converter.
//
// Channel in_i takes one 16-bit code word per beat, with last_word marking
// the final word of a string. Channel out_o gives one EUC-JP byte per beat;
// end_of_run flags the final beat caused by an input word, and an unmapped
// full-width code gives a single beat with invalid_code set and no byte.
// A word flagged last is followed by a zero terminator beat.
// A word accepted from in_i goes into the queue, then from its head into the
// output register. Throughput: one output beat per cycle while the receiver
// is ready, so a word takes one to five beats (its byte count, terminator
// included), set by the single byte output register. Classified words wait
// in a QueueDepth-entry queue, so input is taken while earlier words go out.
// Reset empties the queue and clears the output valid and byte index; the
// payload is not cleared. When the receiver stalls, the current beat holds
// in the output register, the queue fills, and then in_i.ready drops.
module wide_code_to_euc_jp_top #(
  parameter int unsigned QueueDepth = wcej_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wcej_in_if.sink    in_i,
  wcej_out_if.source out_o
);
  import wcej_pkg::*;

  entry_t entry;
  entry_t head;
  logic   full;
  logic   empty;
  logic   pop;

  wcej_front u_front (
    .code_word_i (in_i.code_word),
    .last_word_i (in_i.last_word),
    .entry_o     (entry)
  );

  assign in_i.ready = !full;

  wcej_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_i.valid),
    .push_entry_i (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  wcej_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
